// ===== rtl/cdll_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cdll_pkg;
    localparam logic [3:0] OP_INS_FRONT = 4'd0;
    localparam logic [3:0] OP_INS_BACK  = 4'd1;
    localparam logic [3:0] OP_INS_MID   = 4'd2;
    localparam logic [3:0] OP_DEL_FRONT = 4'd3;
    localparam logic [3:0] OP_DEL_BACK  = 4'd4;
    localparam logic [3:0] OP_DEL_MID   = 4'd5;
    localparam logic [3:0] OP_COUNT     = 4'd6;
    localparam logic [3:0] OP_WALK_FWD  = 4'd7;
    localparam logic [3:0] OP_WALK_BACK = 4'd8;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
        logic        last;
    } result_t;
endpackage
`default_nettype wire

// ===== rtl/circular_doubly_linked_list_manager_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pool-based circular doubly linked list. After reset busy stays high while the free chain is
// built. A request is taken when start is high and busy is low; busy stays high until its last
// result has been issued. Count, undefined ops and rejected requests end in the decode state;
// front and back inserts pass through the read, link and second link states, and deletes through
// the read, unlink and free states. Middle ops first walk the ring one link at a time through the
// registered link memories. A walk gives one result per node, each from a read and an output state.
// Each result is registered and appears in the cycle after its state of work, is shown for one cycle
// with done high, and the receiver cannot stall it.
module circular_doubly_linked_list_manager_core #(
    parameter int CAPACITY   = 32,
    parameter int VALUE_BITS = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [3:0]         op,
    input  wire logic signed [31:0] item_value,
    input  wire logic [5:0]         position,
    output logic                    done,
    output logic [1:0]              status,
    output logic signed [31:0]      out_value,
    output logic [5:0]              node_count,
    output logic                    last
);
    import cdll_pkg::*;

    localparam int IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_WALK  = 4'd3;
    localparam logic [3:0] S_RDT   = 4'd4;
    localparam logic [3:0] S_LINK  = 4'd5;
    localparam logic [3:0] S_LINK2 = 4'd6;
    localparam logic [3:0] S_UNL   = 4'd7;
    localparam logic [3:0] S_UNL2  = 4'd8;
    localparam logic [3:0] S_TRV   = 4'd9;
    localparam logic [3:0] S_TRV2  = 4'd10;
    localparam logic [3:0] S_FREE  = 4'd11;
    localparam logic [3:0] S_ADV   = 4'd12;

    logic [VALUE_BITS-1:0] vmem [CAPACITY];
    logic [IW-1:0]         nmem [CAPACITY];
    logic [IW-1:0]         pmem [CAPACITY];

    logic [3:0]  state_reg;
    logic [IW:0] init_reg;
    logic [3:0]  op_reg;
    logic [31:0] val_reg;
    logic [5:0]  pos_reg;
    logic [IW-1:0] head_reg, tail_reg, free_reg, t_reg, n_reg, p_reg;
    logic [CW-1:0] cnt_reg;
    logic [5:0]  step_reg;
    logic [IW-1:0] rn_q, rp_q;
    logic [VALUE_BITS-1:0] rv_q;
    logic [IW-1:0] raddr;
    logic        fire;
    result_t     res;

    // link memories: one write port each, registered read
    logic          nwe, pwe, vwe;
    logic [IW-1:0] nwa, pwa;
    logic [IW-1:0] nwd, pwd;
    logic [VALUE_BITS-1:0] vwd;

    assign vwd = VALUE_BITS'(signed'(val_reg));

    always_ff @(posedge clk)
    begin
        if (nwe)
        begin
            nmem[nwa] <= nwd;
        end
        if (pwe)
        begin
            pmem[pwa] <= pwd;
        end
        if (vwe)
        begin
            vmem[free_reg] <= vwd;
        end
        rn_q <= nmem[raddr];
        rp_q <= pmem[raddr];
        rv_q <= vmem[raddr];
    end

    logic signed [31:0] rv_ext;
    always_comb
    begin
        if (VALUE_BITS >= 32)
        begin
            rv_ext = 32'(rv_q);
        end
        else
        begin
            rv_ext = 32'(signed'(rv_q));
        end
    end

    logic midok;
    assign midok = (pos_reg > 6'd1) && (7'(cnt_reg) > {1'b0, pos_reg});

    logic [CW-1:0] cnt_m1;
    assign cnt_m1 = cnt_reg - CW'(1);

    logic [IW-1:0] tnext;
    assign tnext = (op_reg == OP_WALK_BACK) ? rp_q : rn_q;

    always_comb
    begin
        nwe = 1'b0; pwe = 1'b0; vwe = 1'b0;
        nwa = t_reg; pwa = t_reg; nwd = t_reg; pwd = t_reg;
        raddr = t_reg;
        fire = 1'b0;
        res = '{status: ST_OK, value: 32'd0, last: 1'b1};
        case (state_reg)
            S_INIT:
            begin
                nwe = 1'b1;
                nwa = init_reg[IW-1:0];
                nwd = (init_reg[IW-1:0] == IW'(CAPACITY - 1)) ? '0 : init_reg[IW-1:0] + IW'(1);
            end
            S_DEC:
            begin
                raddr = free_reg;
                case (op_reg)
                    OP_INS_FRONT, OP_INS_BACK, OP_INS_MID:
                    begin
                        if (cnt_reg == CW'(CAPACITY))
                        begin
                            fire = 1'b1; res.status = ST_FULL;
                        end
                        else if (op_reg == OP_INS_MID && cnt_reg != '0 && !midok)
                        begin
                            fire = 1'b1; res.status = ST_BADPOS;
                        end
                        else
                        begin
                            vwe = 1'b1;
                        end
                    end
                    OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_MID:
                    begin
                        if (cnt_reg == '0)
                        begin
                            fire = 1'b1; res.status = ST_EMPTY;
                        end
                        else if (op_reg == OP_DEL_MID && !midok)
                        begin
                            fire = 1'b1; res.status = ST_BADPOS;
                        end
                    end
                    OP_WALK_FWD, OP_WALK_BACK:
                    begin
                        if (cnt_reg == '0)
                        begin
                            fire = 1'b1; res.status = ST_EMPTY;
                        end
                    end
                    default:
                    begin
                        fire = 1'b1;
                    end
                endcase
            end
            S_WALK:
            begin
                raddr = t_reg;
            end
            S_RDT:
            begin
                raddr = t_reg;
            end
            S_LINK:
            begin
                raddr = n_reg;
                if (cnt_reg == '0)
                begin
                    nwe = 1'b1; nwa = n_reg; nwd = n_reg;
                    pwe = 1'b1; pwa = n_reg; pwd = n_reg;
                end
                else
                begin
                    nwe = 1'b1; nwa = n_reg; nwd = t_reg;
                    pwe = 1'b1; pwa = n_reg; pwd = rp_q;
                end
            end
            S_LINK2:
            begin
                if (cnt_reg != '0)
                begin
                    nwe = 1'b1; nwa = p_reg; nwd = n_reg;
                    pwe = 1'b1; pwa = t_reg; pwd = n_reg;
                end
                fire = 1'b1;
            end
            S_UNL:
            begin
                if (cnt_reg > CW'(1))
                begin
                    nwe = 1'b1; nwa = rp_q; nwd = rn_q;
                    pwe = 1'b1; pwa = rn_q; pwd = rp_q;
                end
            end
            S_FREE:
            begin
                nwe = 1'b1; nwa = t_reg; nwd = free_reg;
                fire = 1'b1;
            end
            S_TRV:
            begin
                raddr = t_reg;
            end
            S_TRV2:
            begin
                raddr = t_reg;
                fire = 1'b1;
                res.value = rv_ext;
                res.last = (step_reg == 6'(cnt_m1));
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            init_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            free_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_INIT:
                begin
                    init_reg <= init_reg + (IW+1)'(1);
                    if (init_reg == (IW+1)'(CAPACITY - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    if (fire)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (op_reg == OP_INS_FRONT || op_reg == OP_INS_BACK
                             || op_reg == OP_INS_MID)
                    begin
                        step_reg <= 6'd1;
                        n_reg <= free_reg;
                        t_reg <= head_reg;
                        state_reg <= (op_reg == OP_INS_MID && cnt_reg != '0) ? S_WALK : S_RDT;
                    end
                    else if (op_reg == OP_WALK_FWD || op_reg == OP_WALK_BACK)
                    begin
                        t_reg <= (op_reg == OP_WALK_FWD) ? head_reg : tail_reg;
                        step_reg <= 6'd0;
                        state_reg <= S_TRV;
                    end
                    else
                    begin
                        step_reg <= 6'd1;
                        t_reg <= (op_reg == OP_DEL_FRONT) ? head_reg :
                                 (op_reg == OP_DEL_BACK) ? tail_reg : head_reg;
                        state_reg <= (op_reg == OP_DEL_MID) ? S_WALK : S_RDT;
                    end
                end
                S_WALK:
                begin
                    if (step_reg == pos_reg)
                    begin
                        state_reg <= S_RDT;
                    end
                    else
                    begin
                        state_reg <= S_ADV;
                    end
                end
                S_ADV:
                begin
                    t_reg <= rn_q;
                    step_reg <= step_reg + 6'd1;
                    state_reg <= S_WALK;
                end
                S_RDT:
                begin
                    if (op_reg == OP_INS_FRONT || op_reg == OP_INS_BACK
                        || op_reg == OP_INS_MID)
                    begin
                        state_reg <= S_LINK;
                    end
                    else
                    begin
                        state_reg <= S_UNL;
                    end
                end
                S_LINK:
                begin
                    p_reg <= rp_q;
                    if (cnt_reg == '0)
                    begin
                        head_reg <= n_reg;
                        tail_reg <= n_reg;
                    end
                    else if (op_reg == OP_INS_FRONT)
                    begin
                        head_reg <= n_reg;
                    end
                    else if (op_reg == OP_INS_BACK)
                    begin
                        tail_reg <= n_reg;
                    end
                    state_reg <= S_LINK2;
                end
                S_LINK2:
                begin
                    free_reg <= rn_q;
                    cnt_reg <= cnt_reg + CW'(1);
                    state_reg <= S_IDLE;
                end
                S_UNL:
                begin
                    if (cnt_reg <= CW'(1))
                    begin
                        head_reg <= '0;
                        tail_reg <= '0;
                    end
                    else
                    begin
                        if (t_reg == head_reg)
                        begin
                            head_reg <= rn_q;
                        end
                        if (t_reg == tail_reg)
                        begin
                            tail_reg <= rp_q;
                        end
                    end
                    state_reg <= S_FREE;
                end
                S_FREE:
                begin
                    free_reg <= t_reg;
                    cnt_reg <= cnt_m1;
                    state_reg <= S_IDLE;
                end
                S_TRV:
                begin
                    state_reg <= S_TRV2;
                end
                S_TRV2:
                begin
                    t_reg <= tnext;
                    step_reg <= step_reg + 6'd1;
                    state_reg <= (step_reg == 6'(cnt_m1)) ? S_IDLE : S_TRV;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            op_reg  <= op;
            val_reg <= item_value;
            pos_reg <= position;
        end
    end

    logic [5:0] cnt_out;
    always_comb
    begin
        cnt_out = 6'(cnt_reg);
        if (state_reg == S_LINK2)
        begin
            cnt_out = 6'(cnt_reg + CW'(1));
        end
        else if (state_reg == S_FREE)
        begin
            cnt_out = 6'(cnt_m1);
        end
    end

    assign busy = (state_reg != S_IDLE);

    cdll_result_reg u_res
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .res        (res),
        .count_in   (cnt_out),
        .done       (done),
        .status     (status),
        .out_value  (out_value),
        .node_count (node_count),
        .last       (last)
    );
endmodule
`default_nettype wire

// ===== rtl/cdll_result_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cdll_result_reg
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  wire cdll_pkg::result_t res,
    input  wire logic [5:0]      count_in,
    output logic                 done,
    output logic [1:0]           status,
    output logic signed [31:0]   out_value,
    output logic [5:0]           node_count,
    output logic                 last
);
    import cdll_pkg::*;

    logic done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status     <= res.status;
            out_value  <= res.value;
            node_count <= count_in;
            last       <= res.last;
        end
    end

    assign done = done_reg;
endmodule
`default_nettype wire

// ===== tb/cdll_checker.sv =====
`timescale 1ns / 1ps
module cdll_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [3:0]         op,
    input  logic signed [31:0] item_value,
    input  logic [5:0]         position,
    input  logic               done,
    input  logic [1:0]         status,
    input  logic signed [31:0] out_value,
    input  logic [5:0]         node_count,
    input  logic               last,
    output int                 fail_count,
    output int                 pending,
    output int                 result_total
);
    import cdll_pkg::*;

    localparam int DEPTH = 32;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
        logic [5:0]  count;
        logic        last;
    } list_result_t;

    list_result_t awaited_results[$];
    logic [31:0] pool_value [DEPTH];
    logic [4:0]  pool_next [DEPTH];
    logic [4:0]  pool_prev [DEPTH];
    logic [4:0]  head_at;
    logic [4:0]  tail_at;
    logic [4:0]  free_at;
    int          list_len;

    assign pending = awaited_results.size();

    function automatic logic [4:0] seek_position(input int pos);
        logic [4:0] t;
        t = head_at;
        for (int i = 1; i < pos && i < DEPTH; i++)
            t = pool_next[t];
        return t;
    endfunction

    task automatic push_result(input logic [1:0] st, input logic [31:0] v, input logic lst);
        list_result_t r;
        r.status = st;
        r.value = v;
        r.count = list_len[5:0];
        r.last = lst;
        awaited_results.push_back(r);
    endtask

    task automatic splice_before(input logic [4:0] n, input logic [4:0] t);
        logic [4:0] p;
        p = pool_prev[t];
        pool_next[n] = t;
        pool_prev[n] = p;
        pool_next[p] = n;
        pool_prev[t] = n;
    endtask

    task automatic remove_entry(input logic [4:0] t);
        logic [4:0] p;
        logic [4:0] q;
        p = pool_prev[t];
        q = pool_next[t];
        if (list_len <= 1) begin
            head_at = '0;
            tail_at = '0;
        end
        else begin
            pool_next[p] = q;
            pool_prev[q] = p;
            if (t == head_at)
                head_at = q;
            if (t == tail_at)
                tail_at = p;
        end
        pool_next[t] = free_at;
        free_at = t;
        list_len--;
    endtask

    task automatic predict_request(input logic [3:0] code, input logic [31:0] v,
                                   input logic [5:0] pos);
        logic [1:0] st;
        logic [4:0] n;
        logic [4:0] t;
        bit         mid_ok;
        st = ST_OK;
        mid_ok = pos > 1 && pos < list_len;
        case (code)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_MID:
            begin
                if (list_len >= DEPTH)
                    st = ST_FULL;
                else if (code == OP_INS_MID && list_len != 0 && !mid_ok)
                    st = ST_BADPOS;
                else begin
                    n = free_at;
                    free_at = pool_next[n];
                    pool_value[n] = v;
                    if (list_len == 0) begin
                        pool_next[n] = n;
                        pool_prev[n] = n;
                        head_at = n;
                        tail_at = n;
                    end
                    else if (code == OP_INS_FRONT) begin
                        splice_before(n, head_at);
                        head_at = n;
                    end
                    else if (code == OP_INS_BACK) begin
                        splice_before(n, head_at);
                        tail_at = n;
                    end
                    else
                        splice_before(n, seek_position(pos));
                    list_len++;
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_MID:
            begin
                if (list_len == 0)
                    st = ST_EMPTY;
                else if (code == OP_DEL_MID && !mid_ok)
                    st = ST_BADPOS;
                else begin
                    t = (code == OP_DEL_FRONT) ? head_at :
                        (code == OP_DEL_BACK) ? tail_at : seek_position(pos);
                    remove_entry(t);
                end
            end
            OP_WALK_FWD, OP_WALK_BACK:
            begin
                if (list_len == 0)
                    st = ST_EMPTY;
                else begin
                    t = (code == OP_WALK_FWD) ? head_at : tail_at;
                    for (int k = 0; k < list_len; k++) begin
                        push_result(ST_OK, pool_value[t], k + 1 == list_len);
                        t = (code == OP_WALK_FWD) ? pool_next[t] : pool_prev[t];
                    end
                    return;
                end
            end
            default:
            begin
            end
        endcase
        push_result(st, '0, 1'b1);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                pool_next[i] = 5'((i + 1) % DEPTH);
                pool_prev[i] = '0;
                pool_value[i] = '0;
            end
            head_at = '0;
            tail_at = '0;
            free_at = '0;
            list_len = 0;
            fail_count = 0;
            result_total = 0;
            awaited_results.delete();
        end
        else begin
            if (done) begin
                list_result_t want;
                result_total++;
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result status=%0d value=%0d count=%0d last=%0b",
                             $time, status, out_value, node_count, last);
                    fail_count++;
                end
                else begin
                    want = awaited_results.pop_front();
                    if (status !== want.status) begin
                        $display("%0t: status expected %0d, got %0d", $time, want.status, status);
                        fail_count++;
                    end
                    if (out_value !== want.value) begin
                        $display("%0t: out_value expected %0d, got %0d", $time,
                                 $signed(want.value), out_value);
                        fail_count++;
                    end
                    if (node_count !== want.count) begin
                        $display("%0t: node_count expected %0d, got %0d", $time,
                                 want.count, node_count);
                        fail_count++;
                    end
                    if (last !== want.last) begin
                        $display("%0t: last expected %0b, got %0b", $time, want.last, last);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                predict_request(op, item_value, position);
        end
    end
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import cdll_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [3:0]         op;
    logic signed [31:0] item_value;
    logic [5:0]         position;
    logic               done;
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic [5:0]         node_count;
    logic               last;
    int                 fail_count;
    int                 pending;
    int                 result_total;
    int                 cycle_count = 0;
    int                 gap_percent;
    int                 shadow_len;
    int                 sent_total;

    circular_doubly_linked_list_manager_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .item_value(item_value), .position(position), .done(done), .status(status),
        .out_value(out_value), .node_count(node_count), .last(last)
    );

    cdll_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .item_value(item_value), .position(position), .done(done), .status(status),
        .out_value(out_value), .node_count(node_count), .last(last),
        .fail_count(fail_count), .pending(pending), .result_total(result_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("circular_doubly_linked_list_manager_core regression: fail");
            $finish;
        end
    end

    // Holds start for exactly one transfer, after a random idle gap.
    task automatic issue_request(input logic [3:0] code, input logic [31:0] v,
                                 input logic [5:0] pos);
        @(negedge clk);
        while ($urandom_range(99) < gap_percent)
            @(negedge clk);
        while (busy)
            @(negedge clk);
        start <= 1'b1;
        op <= code;
        item_value <= v;
        position <= pos;
        @(posedge clk);
        @(negedge clk);
        start <= 1'b0;
        sent_total++;
        case (code)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_MID:
                if (shadow_len < 32 && !(code == OP_INS_MID && shadow_len != 0 &&
                    !(pos > 1 && pos < shadow_len)))
                    shadow_len++;
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_MID:
                if (shadow_len > 0 && !(code == OP_DEL_MID && !(pos > 1 && pos < shadow_len)))
                    shadow_len--;
            default:
            begin
            end
        endcase
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_request();
        int pick;
        logic [3:0] code;
        logic [5:0] pos;
        pick = $urandom_range(99);
        if (pick < 3)
            code = 4'($urandom_range(15, 9));
        else if (pick < 55 && shadow_len < 28)
            code = 4'($urandom_range(OP_INS_MID, OP_INS_FRONT));
        else if (pick < 80)
            code = 4'($urandom_range(OP_DEL_MID, OP_DEL_FRONT));
        else
            code = 4'($urandom_range(OP_WALK_BACK, OP_COUNT));
        if ($urandom_range(9) == 0 || shadow_len < 3)
            pos = 6'($urandom);
        else
            pos = 6'($urandom_range(shadow_len - 1, 2));
        issue_request(code, random_value(), pos);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_COUNT;
        item_value = '0;
        position = '0;
        gap_percent = 0;
        shadow_len = 0;
        sent_total = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        issue_request(OP_WALK_FWD, '0, '0);
        issue_request(OP_DEL_FRONT, '0, '0);
        issue_request(OP_DEL_BACK, '0, '0);
        issue_request(OP_DEL_MID, '0, 6'd2);
        issue_request(OP_INS_MID, 32'h8000_0000, 6'd63);
        issue_request(OP_DEL_BACK, '0, '0);
        issue_request(OP_INS_FRONT, 32'h7fff_ffff, '0);
        issue_request(OP_INS_BACK, 32'hffff_ffff, '0);
        issue_request(OP_INS_MID, 32'd5, 6'd1);
        issue_request(OP_INS_BACK, 32'd0, '0);
        issue_request(OP_INS_MID, 32'h5555_5555, 6'd2);
        issue_request(OP_DEL_MID, '0, 6'd4);
        issue_request(OP_WALK_BACK, '0, '0);
        issue_request(OP_DEL_MID, '0, 6'd2);
        issue_request(4'd15, '0, 6'd63);
        issue_request(OP_COUNT, '0, '0);
        for (int i = 0; i < 32; i++)
            issue_request(OP_INS_FRONT, $urandom, 6'($urandom));
        issue_request(OP_INS_BACK, 32'haaaa_aaaa, '0);
        issue_request(OP_DEL_MID, '0, 6'd31);
        issue_request(OP_WALK_FWD, '0, '0);
        while (pending != 0)
            @(negedge clk);

        for (int phase = 0; phase < 4; phase++) begin
            gap_percent = (phase == 1) ? 57 : (phase == 3) ? 7 : 0;
            for (int i = 0; i < 22; i++)
                random_request();
            while (pending != 0)
                @(negedge clk);
        end
        while (shadow_len > 0)
            issue_request(OP_DEL_FRONT, '0, '0);
        issue_request(OP_WALK_BACK, '0, '0);

        while (pending != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
        $display("Covered %0d requests and %0d results across all ops, full and empty pool,",
                 sent_total, result_total);
        $display("bad middle positions, undefined ops and several idle-gap phases.");
        if (fail_count == 0)
            $display("circular_doubly_linked_list_manager_core regression: pass");
        else
            $display("circular_doubly_linked_list_manager_core regression: fail");
        $finish;
    end
endmodule
